// ===== sv/cfsb_pkg.sv =====
`default_nettype none
package cfsb_pkg;

    localparam int MAX_VERTS    = 64;
    localparam int ST_FRAC_BITS = 13;

    localparam int COORD_W = 24;
    localparam int ST_W    = 16;
    localparam int SUM_W   = 31;
    localparam int FACE_W  = 3;
    localparam int ACT_W   = 2;
    localparam int CNT_W   = $clog2(MAX_VERTS + 1);
    localparam int ADDR_W  = $clog2(MAX_VERTS);
    localparam int VERT_W  = 3 * COORD_W;
    localparam int NUM_W   = COORD_W + ST_FRAC_BITS;
    localparam int CMDQ_DEPTH = 2;

    localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
    localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_VERTEX = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_READ,
        CMD_POLY
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [FACE_W-1:0] face;
        logic [CNT_W-1:0]  count;
        logic              ovf;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD,
        BK_DIV_S,
        BK_DIV_T,
        BK_UPD,
        BK_EMIT
    } t_back_state;

    typedef enum logic [1:0] {
        ROLE_S,
        ROLE_T,
        ROLE_D
    } t_role;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } t_axis;

    typedef struct packed {
        logic  neg;
        t_axis axis;
    } t_axis_ref;

    // face rows {s, t, depth}
    function automatic t_axis_ref axis_ref(logic [FACE_W-1:0] f, t_role role);
        t_axis_ref s_ref;
        t_axis_ref t_ref;
        t_axis_ref d_ref;
        t_axis_ref r;
        case (f)
            FACE_PX: begin
                s_ref = '{1'b1, AX_Y}; t_ref = '{1'b0, AX_Z}; d_ref = '{1'b0, AX_X};
            end
            FACE_NX: begin
                s_ref = '{1'b0, AX_Y}; t_ref = '{1'b0, AX_Z}; d_ref = '{1'b1, AX_X};
            end
            FACE_PY: begin
                s_ref = '{1'b0, AX_X}; t_ref = '{1'b0, AX_Z}; d_ref = '{1'b0, AX_Y};
            end
            FACE_NY: begin
                s_ref = '{1'b1, AX_X}; t_ref = '{1'b0, AX_Z}; d_ref = '{1'b1, AX_Y};
            end
            FACE_PZ: begin
                s_ref = '{1'b1, AX_Y}; t_ref = '{1'b1, AX_X}; d_ref = '{1'b0, AX_Z};
            end
            default: begin
                s_ref = '{1'b1, AX_Y}; t_ref = '{1'b0, AX_X}; d_ref = '{1'b1, AX_Z};
            end
        endcase
        case (role)
            ROLE_S:  r = s_ref;
            ROLE_T:  r = t_ref;
            default: r = d_ref;
        endcase
        return r;
    endfunction

    function automatic logic signed [COORD_W:0] pick_axis(
        logic [FACE_W-1:0] f, t_role role,
        logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
        logic signed [COORD_W-1:0] z);
        t_axis_ref r;
        logic signed [COORD_W:0] v;
        r = axis_ref(f, role);
        case (r.axis)
            AX_X:    v = (COORD_W+1)'(x);
            AX_Y:    v = (COORD_W+1)'(y);
            default: v = (COORD_W+1)'(z);
        endcase
        return r.neg ? -v : v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/cfsb_ram.sv =====
`default_nettype none
module cfsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// ===== sv/cfsb_cmd_q.sv =====
`default_nettype none
module cfsb_cmd_q (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire cfsb_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output cfsb_pkg::t_cmd     o_cmd,
    output logic               o_empty
);
    import cfsb_pkg::*;

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int QCNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd              r_slot [CMDQ_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/cfsb_front.sv =====
`default_nettype none
module cfsb_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_push,
    output logic                                    o_full,
    input  wire logic [cfsb_pkg::ACT_W-1:0]         i_action,
    input  wire logic signed [cfsb_pkg::COORD_W-1:0] i_vx,
    input  wire logic signed [cfsb_pkg::COORD_W-1:0] i_vy,
    input  wire logic signed [cfsb_pkg::COORD_W-1:0] i_vz,
    input  wire logic                               i_last_vertex,
    input  wire logic [cfsb_pkg::FACE_W-1:0]        i_face_select,
    output logic                                    o_wr_en,
    output logic [cfsb_pkg::ADDR_W-1:0]             o_wr_addr,
    output logic [cfsb_pkg::VERT_W-1:0]             o_wr_data,
    output logic                                    o_cmd_push,
    output cfsb_pkg::t_cmd                          o_cmd,
    input  wire logic                               i_cmd_full,
    input  wire logic                               i_store_free
);
    import cfsb_pkg::*;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y, r_sum_z;
    logic signed [SUM_W-1:0] n_sum_x, n_sum_y, n_sum_z;
    logic                    r_poly_ovf;
    logic                    r_store_busy;
    logic                    accept;
    logic                    can_store;
    logic                    is_vertex;
    logic                    poly_end;
    logic [SUM_W-1:0]        mag_x, mag_y, mag_z;
    logic [FACE_W-1:0]       poly_face;
    t_action                 act;

    function automatic logic signed [SUM_W-1:0] sat_sum(
        logic signed [SUM_W-1:0] s, logic signed [COORD_W-1:0] v);
        logic signed [SUM_W:0] w;
        w = (SUM_W+1)'(s) + (SUM_W+1)'(v);
        if (w[SUM_W] != w[SUM_W-1]) begin
            return w[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return w[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] mag(logic signed [SUM_W-1:0] s);
        return s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    endfunction

    assign o_full    = r_store_busy || i_cmd_full;
    assign accept    = i_push && !o_full;
    assign act       = t_action'(i_action);
    assign can_store = (r_count < CNT_W'(MAX_VERTS));
    assign is_vertex = accept && (act == ACT_VERTEX);
    assign poly_end  = is_vertex && i_last_vertex;

    assign n_sum_x = can_store ? sat_sum(r_sum_x, i_vx) : r_sum_x;
    assign n_sum_y = can_store ? sat_sum(r_sum_y, i_vy) : r_sum_y;
    assign n_sum_z = can_store ? sat_sum(r_sum_z, i_vz) : r_sum_z;
    assign n_count = can_store ? r_count + 1'b1 : r_count;
    assign mag_x   = mag(n_sum_x);
    assign mag_y   = mag(n_sum_y);
    assign mag_z   = mag(n_sum_z);

    // strict max wins; any tie falls to z
    always_comb begin
        if (mag_x > mag_y && mag_x > mag_z) begin
            poly_face = n_sum_x[SUM_W-1] ? FACE_NX : FACE_PX;
        end else if (mag_y > mag_z && mag_y > mag_x) begin
            poly_face = n_sum_y[SUM_W-1] ? FACE_NY : FACE_PY;
        end else begin
            poly_face = n_sum_z[SUM_W-1] ? FACE_NZ : FACE_PZ;
        end
    end

    assign o_wr_en   = is_vertex && can_store;
    assign o_wr_addr = r_count[ADDR_W-1:0];
    assign o_wr_data = {i_vx, i_vy, i_vz};

    always_comb begin
        o_cmd_push = 1'b0;
        o_cmd      = '{kind: CMD_CLEAR, face: poly_face, count: n_count,
                       ovf: r_poly_ovf || !can_store};
        if (accept) begin
            unique case (act)
                ACT_CLEAR: begin
                    o_cmd_push = 1'b1;
                end
                ACT_READ: begin
                    o_cmd_push = 1'b1;
                    o_cmd.kind = CMD_READ;
                    o_cmd.face = (i_face_select > FACE_NZ) ? FACE_NZ : i_face_select;
                end
                ACT_VERTEX: begin
                    o_cmd_push = i_last_vertex;
                    o_cmd.kind = CMD_POLY;
                end
                default: begin
                    o_cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_sum_x      <= '0;
            r_sum_y      <= '0;
            r_sum_z      <= '0;
            r_poly_ovf   <= 1'b0;
            r_store_busy <= 1'b0;
        end else begin
            if (poly_end) begin
                r_count      <= '0;
                r_sum_x      <= '0;
                r_sum_y      <= '0;
                r_sum_z      <= '0;
                r_poly_ovf   <= 1'b0;
                r_store_busy <= 1'b1;
            end else begin
                if (is_vertex) begin
                    r_count    <= n_count;
                    r_sum_x    <= n_sum_x;
                    r_sum_y    <= n_sum_y;
                    r_sum_z    <= n_sum_z;
                    r_poly_ovf <= r_poly_ovf || !can_store;
                end
                if (i_store_free) begin
                    r_store_busy <= 1'b0;
                end
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTS))
        else $error("vertex count past store depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |-> !i_cmd_full)
        else $error("command pushed into full queue");
    a_busy_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        poly_end |=> r_store_busy && r_count == '0)
        else $error("store not locked after polygon end");
`endif
endmodule
`default_nettype wire

// ===== sv/cfsb_div.sv =====
`default_nettype none
module cfsb_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [cfsb_pkg::COORD_W:0]  i_num,
    input  wire logic signed [cfsb_pkg::COORD_W:0]  i_den,
    output logic                                    o_done,
    output logic signed [cfsb_pkg::ST_W-1:0]        o_quo,
    output logic                                    o_sat
);
    import cfsb_pkg::*;

    localparam int DCNT_W = $clog2(NUM_W + 1);

    logic                  r_busy;
    logic [DCNT_W-1:0]     r_cnt;
    logic [NUM_W-1:0]      r_nq;
    logic [COORD_W-1:0]    r_rem;
    logic [COORD_W-1:0]    r_den;
    logic                  r_neg;
    logic                  r_num_neg;
    logic                  r_dz;
    logic [COORD_W:0]      num_abs;
    logic [COORD_W:0]      den_abs;
    logic [COORD_W:0]      trial;
    logic                  ge;
    logic [COORD_W:0]      diff;
    logic                  big_pos;
    logic                  big_neg;

    assign num_abs = i_num[COORD_W] ? (COORD_W+1)'(-i_num) : (COORD_W+1)'(i_num);
    assign den_abs = i_den[COORD_W] ? (COORD_W+1)'(-i_den) : (COORD_W+1)'(i_den);
    assign trial   = {r_rem, r_nq[NUM_W-1]};
    assign ge      = trial >= {1'b0, r_den};
    assign diff    = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq      <= {num_abs[COORD_W-1:0], ST_FRAC_BITS'(0)};
            r_den     <= den_abs[COORD_W-1:0];
            r_rem     <= '0;
            r_neg     <= i_num[COORD_W] ^ i_den[COORD_W];
            r_num_neg <= i_num[COORD_W];
            r_dz      <= (i_den == '0);
        end else if (r_busy && r_cnt != '0) begin
            r_nq  <= {r_nq[NUM_W-2:0], ge};
            r_rem <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= (i_den == '0) ? '0 : DCNT_W'(NUM_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done  = r_busy && (r_cnt == '0);
    assign big_pos = |r_nq[NUM_W-1:ST_W-1];
    assign big_neg = (|r_nq[NUM_W-1:ST_W]) || (r_nq[ST_W-1] && (|r_nq[ST_W-2:0]));

    always_comb begin
        if (r_dz) begin
            o_quo = r_num_neg ? ST_MIN : ST_MAX;
            o_sat = 1'b1;
        end else if (r_neg) begin
            o_quo = big_neg ? ST_MIN : -$signed(r_nq[ST_W-1:0]);
            o_sat = big_neg;
        end else begin
            o_quo = big_pos ? ST_MAX : $signed(r_nq[ST_W-1:0]);
            o_sat = big_pos;
        end
    end
endmodule
`default_nettype wire

// ===== sv/cfsb_back.sv =====
`default_nettype none
module cfsb_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire cfsb_pkg::t_cmd               i_cmd,
    input  wire logic                         i_cmd_empty,
    output logic                              o_cmd_pop,
    output logic [cfsb_pkg::ADDR_W-1:0]       o_rd_addr,
    input  wire logic [cfsb_pkg::VERT_W-1:0]  i_rd_data,
    output logic                              o_store_free,
    output logic                              o_empty,
    input  wire logic                         i_pop,
    output logic [cfsb_pkg::FACE_W-1:0]       o_face,
    output logic signed [cfsb_pkg::ST_W-1:0]  o_s_low,
    output logic signed [cfsb_pkg::ST_W-1:0]  o_s_high,
    output logic signed [cfsb_pkg::ST_W-1:0]  o_t_low,
    output logic signed [cfsb_pkg::ST_W-1:0]  o_t_high,
    output logic                              o_face_empty,
    output logic                              o_overflow
);
    import cfsb_pkg::*;

    localparam int NFACES = 6;

    t_back_state               r_state, n_state;
    logic [CNT_W-1:0]          r_idx;
    logic [CNT_W-1:0]          r_count;
    logic [FACE_W-1:0]         r_face;
    logic                      r_ovf;
    logic signed [COORD_W:0]   r_a_t;
    logic signed [COORD_W:0]   r_den;
    logic signed [ST_W-1:0]    r_s;
    logic signed [ST_W-1:0]    r_t;
    logic                      r_out_valid;
    logic signed [ST_W-1:0]    r_min_s [NFACES];
    logic signed [ST_W-1:0]    r_min_t [NFACES];
    logic signed [ST_W-1:0]    r_max_s [NFACES];
    logic signed [ST_W-1:0]    r_max_t [NFACES];
    logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;
    logic signed [COORD_W:0]   div_num, div_den;
    logic                      div_start;
    logic                      div_done;
    logic signed [ST_W-1:0]    div_quo;
    logic                      div_sat;
    logic                      last_vert;
    logic                      out_load;
    logic signed [ST_W-1:0]    f_min_s, f_min_t, f_max_s, f_max_t;

    assign {rd_x, rd_y, rd_z} = i_rd_data;
    assign o_rd_addr = r_idx[ADDR_W-1:0];
    assign last_vert = ((r_idx + 1'b1) == r_count);
    assign f_min_s   = r_min_s[r_face];
    assign f_min_t   = r_min_t[r_face];
    assign f_max_s   = r_max_s[r_face];
    assign f_max_t   = r_max_t[r_face];

    cfsb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_sat   (div_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd_pop    = 1'b0;
        div_start    = 1'b0;
        div_num      = r_a_t;
        div_den      = r_den;
        o_store_free = 1'b0;
        out_load     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_READ: n_state = BK_EMIT;
                        CMD_POLY: n_state = BK_READ;
                        default:  n_state = BK_IDLE;
                    endcase
                end
            end
            BK_READ: begin
                n_state = BK_LOAD;
            end
            BK_LOAD: begin
                div_start = 1'b1;
                div_num   = pick_axis(r_face, ROLE_S, rd_x, rd_y, rd_z);
                div_den   = pick_axis(r_face, ROLE_D, rd_x, rd_y, rd_z);
                n_state   = BK_DIV_S;
            end
            BK_DIV_S: begin
                if (div_done) begin
                    div_start = 1'b1;
                    n_state   = BK_DIV_T;
                end
            end
            BK_DIV_T: begin
                if (div_done) begin
                    n_state = BK_UPD;
                end
            end
            BK_UPD: begin
                if (last_vert) begin
                    o_store_free = 1'b1;
                    n_state      = BK_EMIT;
                end else begin
                    n_state = BK_READ;
                end
            end
            BK_EMIT: begin
                if (!r_out_valid) begin
                    out_load = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // per-vertex working registers
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_face  <= i_cmd.face;
            r_count <= i_cmd.count;
            r_ovf   <= (i_cmd.kind == CMD_POLY) && i_cmd.ovf;
            r_idx   <= '0;
        end else begin
            if (r_state == BK_LOAD) begin
                r_a_t <= pick_axis(r_face, ROLE_T, rd_x, rd_y, rd_z);
                r_den <= pick_axis(r_face, ROLE_D, rd_x, rd_y, rd_z);
            end
            if (div_done && (r_state == BK_DIV_S || r_state == BK_DIV_T)) begin
                r_ovf <= r_ovf || div_sat;
            end
            if (div_done && r_state == BK_DIV_S) begin
                r_s <= div_quo;
            end
            if (div_done && r_state == BK_DIV_T) begin
                r_t <= div_quo;
            end
            if (r_state == BK_UPD) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // face bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NFACES; i++) begin
                r_min_s[i] <= ST_MAX;
                r_min_t[i] <= ST_MAX;
                r_max_s[i] <= ST_MIN;
                r_max_t[i] <= ST_MIN;
            end
        end else if (o_cmd_pop && i_cmd.kind == CMD_CLEAR) begin
            for (int i = 0; i < NFACES; i++) begin
                r_min_s[i] <= ST_MAX;
                r_min_t[i] <= ST_MAX;
                r_max_s[i] <= ST_MIN;
                r_max_t[i] <= ST_MIN;
            end
        end else if (r_state == BK_UPD) begin
            if (r_s < f_min_s) r_min_s[r_face] <= r_s;
            if (r_t < f_min_t) r_min_t[r_face] <= r_t;
            if (r_s > f_max_s) r_max_s[r_face] <= r_s;
            if (r_t > f_max_t) r_max_t[r_face] <= r_t;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_face       <= r_face;
            o_s_low      <= f_min_s;
            o_s_high     <= f_max_s;
            o_t_low      <= f_min_t;
            o_t_high     <= f_max_t;
            o_face_empty <= (f_min_s >= f_max_s) || (f_min_t >= f_max_t);
            o_overflow   <= r_ovf;
        end
    end

    assign o_empty = !r_out_valid;

`ifndef SYNTH
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_READ || r_state == BK_LOAD || r_state == BK_UPD)
            |-> r_idx < r_count)
        else $error("vertex index past polygon size");
    a_face_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_IDLE) |-> r_face <= FACE_NZ)
        else $error("face out of range");
    a_free_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_store_free |=> r_state == BK_EMIT)
        else $error("store released outside polygon end");
`endif
endmodule
`default_nettype wire

// ===== sv/cube_face_select_and_bounds_core.sv =====
`default_nettype none
// Channel   Direction  Handshake        Payload
// input     in         i_push / o_full  action, vx, vy, vz, last_vertex, face_select
// result    out        o_empty / i_pop  face, s/t low/high, face_empty, overflow
//
// Accepted vertex beats are stored and summed. A last vertex locks the store
// and hands the polygon to the back end, which walks the vertices through one
// shared bit-serial divider: per vertex it reads the store, divides s and then
// t by depth, and updates the face bounds; a zero depth skips the iteration.
// A clear beat resets all face bounds; a read beat waits to emit while the
// result register is full. o_full rises while a polygon is being projected
// or the 2-deep command queue is full; reset is synchronous and active low.
module cube_face_select_and_bounds_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_push,
    output logic                                    o_full,
    input  wire logic [cfsb_pkg::ACT_W-1:0]         i_action,
    input  wire logic signed [cfsb_pkg::COORD_W-1:0] i_vx,
    input  wire logic signed [cfsb_pkg::COORD_W-1:0] i_vy,
    input  wire logic signed [cfsb_pkg::COORD_W-1:0] i_vz,
    input  wire logic                               i_last_vertex,
    input  wire logic [cfsb_pkg::FACE_W-1:0]        i_face_select,
    output logic                                    o_empty,
    input  wire logic                               i_pop,
    output logic [cfsb_pkg::FACE_W-1:0]             o_face,
    output logic signed [cfsb_pkg::ST_W-1:0]        o_s_low,
    output logic signed [cfsb_pkg::ST_W-1:0]        o_s_high,
    output logic signed [cfsb_pkg::ST_W-1:0]        o_t_low,
    output logic signed [cfsb_pkg::ST_W-1:0]        o_t_high,
    output logic                                    o_face_empty,
    output logic                                    o_overflow
);
    import cfsb_pkg::*;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VERT_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [VERT_W-1:0] rd_data;
    logic              cmd_push;
    t_cmd              cmd_in;
    logic              cmd_full;
    logic              cmd_pop;
    t_cmd              cmd_out;
    logic              cmd_empty;
    logic              store_free;

    // front: classify beats, store vertices, pick the face
    cfsb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_action      (i_action),
        .i_vx          (i_vx),
        .i_vy          (i_vy),
        .i_vz          (i_vz),
        .i_last_vertex (i_last_vertex),
        .i_face_select (i_face_select),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in),
        .i_cmd_full    (cmd_full),
        .i_store_free  (store_free)
    );

    // vertex store, x/y/z packed in one word
    cfsb_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_VERTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // keeps clear / read / polygon order between the two halves
    cfsb_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_out),
        .o_empty (cmd_empty)
    );

    // back: projection, bounds and result register
    cfsb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_out),
        .i_cmd_empty  (cmd_empty),
        .o_cmd_pop    (cmd_pop),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_store_free (store_free),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_face       (o_face),
        .o_s_low      (o_s_low),
        .o_s_high     (o_s_high),
        .o_t_low      (o_t_low),
        .o_t_high     (o_t_high),
        .o_face_empty (o_face_empty),
        .o_overflow   (o_overflow)
    );
endmodule
`default_nettype wire
